// File: rtl/core/murmur3_hash_engine_core_defines.svh
`ifndef MURMUR3_HASH_ENGINE_CORE_DEFINES_SVH
`define MURMUR3_HASH_ENGINE_CORE_DEFINES_SVH

// Checked only while out of reset.
`define MH3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checked during reset as well.
`define MH3_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mh3_pkg.sv
package mh3_pkg;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_N   = 32'he6546b64;
  localparam logic [31:0] FIN_F1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_F2  = 32'hc2b2ae35;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_BODY
  } word_kind_t;

  typedef struct packed {
    logic [31:0] k;
    word_kind_t  kind;
    logic        last;
    logic [2:0]  nbytes;
  } mix_item_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_FIN1,
    BK_FIN2,
    BK_EMIT
  } back_state_t;

endpackage

// File: rtl/core/mh3_front.sv
module mh3_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [31:0]        in_key_word,
  input  logic [2:0]         in_valid_bytes,
  input  logic               in_last_word,
  input  logic               q_full,
  output logic               q_push,
  output mh3_pkg::mix_item_t q_item
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [31:0]         s1_prod_r, s1_prod_nxt;
  mh3_pkg::word_kind_t s1_kind_r, s1_kind_nxt;
  logic                s1_last_r, s1_last_nxt;
  logic [2:0]          s1_nbytes_r, s1_nbytes_nxt;
  logic                s2_valid_r, s2_valid_nxt;
  mh3_pkg::mix_item_t  s2_item_r, s2_item_nxt;

  logic        advance;
  logic [2:0]  nbytes;
  logic [31:0] masked;
  logic [31:0] rot15;

  // Whole front moves together; it holds while the queue is full.
  assign advance = !q_full;
  assign in_full = q_full;
  assign q_push  = s2_valid_r && advance;
  assign q_item  = s2_item_r;

  always_comb begin
    // Valid byte count only matters on the last word; 5..7 saturate to 4.
    if (!in_last_word || in_valid_bytes[2]) begin
      nbytes = 3'd4;
    end else begin
      nbytes = in_valid_bytes;
    end

    unique case (nbytes)
      3'd1:    masked = {24'd0, in_key_word[7:0]};
      3'd2:    masked = {16'd0, in_key_word[15:0]};
      3'd3:    masked = {8'd0, in_key_word[23:0]};
      default: masked = in_key_word;
    endcase

    s1_valid_nxt  = s1_valid_r;
    s1_prod_nxt   = s1_prod_r;
    s1_kind_nxt   = s1_kind_r;
    s1_last_nxt   = s1_last_r;
    s1_nbytes_nxt = s1_nbytes_r;
    s2_valid_nxt  = s2_valid_r;
    s2_item_nxt   = s2_item_r;

    rot15 = {s1_prod_r[16:0], s1_prod_r[31:17]};

    if (advance) begin
      s1_valid_nxt  = in_push;
      s1_prod_nxt   = masked * mh3_pkg::MIX_C1;
      s1_last_nxt   = in_last_word;
      s1_nbytes_nxt = nbytes;
      if (nbytes == 3'd4) begin
        s1_kind_nxt = mh3_pkg::KIND_BODY;
      end else if (nbytes == 3'd0) begin
        s1_kind_nxt = mh3_pkg::KIND_NONE;
      end else begin
        s1_kind_nxt = mh3_pkg::KIND_TAIL;
      end

      s2_valid_nxt       = s1_valid_r;
      s2_item_nxt.k      = rot15 * mh3_pkg::MIX_C2;
      s2_item_nxt.kind   = s1_kind_r;
      s2_item_nxt.last   = s1_last_r;
      s2_item_nxt.nbytes = s1_nbytes_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
    s1_prod_r   <= s1_prod_nxt;
    s1_kind_r   <= s1_kind_nxt;
    s1_last_r   <= s1_last_nxt;
    s1_nbytes_r <= s1_nbytes_nxt;
    s2_item_r   <= s2_item_nxt;
  end

endmodule

// File: rtl/core/mh3_fifo.sv
module mh3_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mh3_pkg::mix_item_t push_item,
  output logic               full,
  input  logic               pop,
  output mh3_pkg::mix_item_t pop_item,
  output logic               empty
);

  mh3_pkg::mix_item_t        mem_r [mh3_pkg::QDEPTH];
  logic [mh3_pkg::QAW:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mh3_pkg::QAW:0]     rd_ptr_r, rd_ptr_nxt;

  assign empty    = (wr_ptr_r == rd_ptr_r);
  assign full     = (wr_ptr_r[mh3_pkg::QAW] != rd_ptr_r[mh3_pkg::QAW]) &&
                    (wr_ptr_r[mh3_pkg::QAW-1:0] == rd_ptr_r[mh3_pkg::QAW-1:0]);
  assign pop_item = mem_r[rd_ptr_r[mh3_pkg::QAW-1:0]];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push && !full) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
    if (push && !full) begin
      mem_r[wr_ptr_r[mh3_pkg::QAW-1:0]] <= push_item;
    end
  end

endmodule

// File: rtl/core/mh3_back.sv
module mh3_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        seed,
  input  mh3_pkg::mix_item_t q_item,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_valid,
  output logic [31:0]        out_hash
);

  mh3_pkg::back_state_t state_r, state_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] len_r, len_nxt;
  logic        start_r, start_nxt;
  logic [31:0] fin_r, fin_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] h_in, len_in, hx, hr, h_body, h_mixed, len_sum;
  logic [31:0] av1, av2;

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

  always_comb begin
    // Seed and length restart on the first word of every key.
    h_in    = start_r ? seed : hash_r;
    len_in  = start_r ? 32'd0 : len_r;
    hx      = h_in ^ q_item.k;
    hr      = {hx[18:0], hx[31:19]};
    h_body  = (hr << 2) + hr + mh3_pkg::MIX_N;
    len_sum = len_in + {29'd0, q_item.nbytes};
    av1     = fin_r ^ (fin_r >> 16);
    av2     = fin_r ^ (fin_r >> 13);

    unique case (q_item.kind)
      mh3_pkg::KIND_BODY: h_mixed = h_body;
      mh3_pkg::KIND_TAIL: h_mixed = hx;
      default:            h_mixed = h_in;
    endcase

    state_nxt     = state_r;
    hash_nxt      = hash_r;
    len_nxt       = len_r;
    start_nxt     = start_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_hash_nxt  = out_hash_r;
    q_pop         = 1'b0;

    unique case (state_r)
      mh3_pkg::BK_RUN: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.last) begin
            fin_nxt   = h_mixed ^ len_sum;
            start_nxt = 1'b1;
            state_nxt = mh3_pkg::BK_FIN1;
          end else begin
            hash_nxt  = h_body;
            len_nxt   = len_sum;
            start_nxt = 1'b0;
          end
        end
      end
      mh3_pkg::BK_FIN1: begin
        fin_nxt   = av1 * mh3_pkg::FIN_F1;
        state_nxt = mh3_pkg::BK_FIN2;
      end
      mh3_pkg::BK_FIN2: begin
        fin_nxt   = av2 * mh3_pkg::FIN_F2;
        state_nxt = mh3_pkg::BK_EMIT;
      end
      mh3_pkg::BK_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = fin_r ^ (fin_r >> 16);
          state_nxt     = mh3_pkg::BK_RUN;
        end
      end
      default: state_nxt = mh3_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mh3_pkg::BK_RUN;
      hash_r      <= '0;
      len_r       <= '0;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      len_r       <= len_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fin_r      <= fin_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

// File: rtl/core/murmur3_hash_engine_core.sv
// MurmurHash3 x86_32 engine. Push a key as little-endian 32-bit words; mark the
// final word with in_last_word and give its byte count (0..4) in in_valid_bytes.
// The running-hash update in the back end (xor, rotate, multiply by five, add)
// accepts one non-final word per clock while in BK_RUN and the queue holds one.
// A final word holds the back end for two avalanche multiplies (BK_FIN1,
// BK_FIN2) and the output load (BK_EMIT), which waits for any earlier hash
// to be popped. A two-stage key scrambler in front feeds a four-item queue, so
// input keeps flowing until the queue fills while a finished hash waits to be
// popped. The seed register loads cfg_hash_seed on cfg_we and is read when
// a new key starts in the back end; write it only while the engine is idle.
module murmur3_hash_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_key_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_hash_value,
  input  logic        cfg_we,
  input  logic [31:0] cfg_hash_seed
);

  logic [31:0]        seed_r, seed_nxt;
  logic               q_full, q_push, q_pop, q_empty;
  mh3_pkg::mix_item_t q_wr_item, q_rd_item;
  logic               out_valid;

  assign seed_nxt  = cfg_we ? cfg_hash_seed : seed_r;
  assign out_empty = !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  mh3_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_key_word    (in_key_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_wr_item)
  );

  mh3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_rd_item),
    .empty     (q_empty)
  );

  mh3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .q_item    (q_rd_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_hash  (out_hash_value)
  );

endmodule

// File: rtl/core/mh3_checker.sv
`include "murmur3_hash_engine_core_defines.svh"

module mh3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_hash_value
);

  // Reset drains both sides.
  `MH3_ASSERT_RST(a_rst_clear, !rst_n, out_empty && !in_full, "reset left a queue occupied")
  // No hash can come out of the pipeline straight after reset.
  `MH3_ASSERT_RST(a_rst_latency, !rst_n, out_empty ##1 out_empty ##1 out_empty, "early hash")
  // A waiting hash stays put until popped.
  `MH3_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_hash_value), "hash dropped")

endmodule

bind murmur3_hash_engine_core mh3_checker u_mh3_checker (.*);
